[rtl/smpc_pkg.sv]
// Package: codes, widths and helpers shared by the servo motion profile controller.
package smpc_pkg;

  localparam int WIDTH_W   = 15;
  localparam int REQ_W     = 16;
  localparam int PAUSE_W   = 16;
  localparam int RAND_W    = 32;
  localparam int CMD_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int SPAN_W    = 16;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX = 15'd20000;

  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PWR_ON = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PWR_OFF = 3'd2;
  localparam logic [CMD_W-1:0] CMD_JUMP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MOVE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RANDOM = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SWEEP  = 3'd6;

  localparam logic [1:0] MODE_FIXED  = 2'd0;
  localparam logic [1:0] MODE_RANDOM = 2'd1;
  localparam logic [1:0] MODE_SWEEP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RPAUSE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPAUSE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIDDLE = 3'd5;

  localparam logic [WIDTH_W-1:0] TOP_RST    = 15'd1000;
  localparam logic [WIDTH_W-1:0] BOTTOM_RST = 15'd2000;
  localparam logic [WIDTH_W-1:0] DELTA_RST  = 15'd10;
  localparam logic [WIDTH_W-1:0] MIDDLE_RST = 15'd1500;

  // Clamp a width to the servo maximum.
  function automatic logic [WIDTH_W-1:0] sat_width(input logic [16:0] w);
    logic [16:0] lim;
    lim = {2'b00, WIDTH_MAX};
    return (w > lim) ? WIDTH_MAX : w[WIDTH_W-1:0];
  endfunction

endpackage

[rtl/smpc_if.sv]
// Stream interfaces: command items, result items and the register write channel.
interface smpc_in_if;
  logic                         valid;
  logic                         ready;
  logic [smpc_pkg::CMD_W-1:0]   command;
  logic [smpc_pkg::REQ_W-1:0]   requested_width;
  logic [smpc_pkg::RAND_W-1:0]  random_value;
  modport source (output valid, command, requested_width, random_value, input ready);
  modport sink (input valid, command, requested_width, random_value, output ready);
endinterface

interface smpc_out_if;
  logic                          valid;
  logic                          ready;
  logic [smpc_pkg::WIDTH_W-1:0]  pulse_out;
  logic                          power_enable;
  logic                          sweep_top_hit;
  logic                          sweep_bottom_hit;
  modport source (output valid, pulse_out, power_enable, sweep_top_hit, sweep_bottom_hit,
                  input ready);
  modport sink (input valid, pulse_out, power_enable, sweep_top_hit, sweep_bottom_hit,
                output ready);
endinterface

interface smpc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [smpc_pkg::CFG_IDX_W-1:0]  index;
  logic [smpc_pkg::CFG_DAT_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/servo_motion_profile_controller.sv]
// Top level: command sequencer, motion state and result register of the servo controller.
// Sequence: an accepted item passes the execute and write-back states; a random-mode tick
//   that picks a new target also passes the divide state, run by the 32-step serial remainder unit.
// Flow: one item at a time; ready returns in the cycle the result is loaded, and write-back
//   waits while the result is held.
// Reset (rst, synchronous): registers to defaults, width and target to 1500, mode fixed,
//   power off, no pause, no result pending.
module servo_motion_profile_controller (
  input  logic        clk,
  input  logic        rst,
  smpc_in_if.sink     item_stream,
  smpc_out_if.source  result_stream,
  smpc_cfg_if.sink    cfg_port
);
  import smpc_pkg::*;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for an item
  localparam logic [1:0] ST_EXEC = 2'd1;  // decide whether a remainder is needed
  localparam logic [1:0] ST_DIV  = 2'd2;  // serial remainder running
  localparam logic [1:0] ST_WB   = 2'd3;  // update state, load result register

  logic [1:0] state;
  logic [1:0] state_next;

  // Configuration registers. The middle width is a fixed reset default with no register,
  // so a write to its index has no effect.
  logic [WIDTH_W-1:0] top_limit;
  logic [WIDTH_W-1:0] bottom_limit;
  logic [WIDTH_W-1:0] step_delta;
  logic [PAUSE_W-1:0] random_pause_ticks;
  logic [PAUSE_W-1:0] sweep_pause_ticks;

  // Motion state
  logic [WIDTH_W-1:0] current_width;
  logic [WIDTH_W-1:0] target_width;
  logic [1:0]         motion_mode;
  logic               powered;
  logic [PAUSE_W-1:0] pause_left;

  // Latched item
  logic [CMD_W-1:0]   cmd;
  logic [WIDTH_W-1:0] req;
  logic [RAND_W-1:0]  rnd;

  // Result register
  logic               out_valid;
  logic [WIDTH_W-1:0] out_pulse;
  logic               out_power;
  logic               out_top;
  logic               out_bottom;

  // Remainder unit
  logic               mod_start;
  logic               mod_done;
  logic [SPAN_W-1:0]  span;
  logic [SPAN_W-1:0]  mod_rem;

  logic at_target;
  logic tick_active;
  logic need_mod;
  logic out_free;

  logic [WIDTH_W-1:0] current_width_next;
  logic [WIDTH_W-1:0] target_width_next;
  logic [1:0]         motion_mode_next;
  logic               powered_next;
  logic [PAUSE_W-1:0] pause_left_next;
  logic               top_hit;
  logic               bottom_hit;

  logic               chose;
  logic               do_step;
  logic [WIDTH_W:0]   mid_sum;
  logic [WIDTH_W-1:0] mid;
  logic [WIDTH_W-1:0] diff;
  logic [WIDTH_W-1:0] move;

  assign item_stream.ready = (state == ST_IDLE);
  assign cfg_port.ready    = 1'b1;

  assign result_stream.valid            = out_valid;
  assign result_stream.pulse_out        = out_pulse;
  assign result_stream.power_enable     = out_power;
  assign result_stream.sweep_top_hit    = out_top;
  assign result_stream.sweep_bottom_hit = out_bottom;

  assign out_free    = !out_valid || result_stream.ready;
  assign at_target   = (current_width == target_width);
  assign tick_active = powered && (!at_target || motion_mode != MODE_FIXED);
  // Only a random-mode tick at the target with no pause pending picks a random target.
  assign need_mod    = (cmd == CMD_TICK) && tick_active && (pause_left == '0)
                       && (motion_mode == MODE_RANDOM) && at_target;

  // Top above bottom collapses the span to one.
  assign span = (bottom_limit >= top_limit)
                ? SPAN_W'({1'b0, bottom_limit} - {1'b0, top_limit} + 16'd1)
                : 16'd1;

  assign mod_start = (state == ST_EXEC) && need_mod;

  smpc_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (rnd),
    .divisor   (span),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Next motion state for the latched item; used in the write-back state.
  always_comb begin
    current_width_next = current_width;
    target_width_next  = target_width;
    motion_mode_next   = motion_mode;
    powered_next       = powered;
    pause_left_next    = pause_left;
    top_hit            = 1'b0;
    bottom_hit         = 1'b0;
    chose              = 1'b0;
    do_step            = 1'b0;
    mid_sum            = {1'b0, top_limit} + {1'b0, bottom_limit};
    mid                = mid_sum[WIDTH_W:1];

    case (cmd)
      CMD_TICK: begin
        if (tick_active) begin
          if (pause_left != '0) begin
            pause_left_next = pause_left - 1'b1;
            do_step = (pause_left_next == '0);
          end else begin
            if (motion_mode == MODE_RANDOM && at_target) begin
              target_width_next = sat_width({2'b00, top_limit} + {1'b0, mod_rem});
              pause_left_next   = random_pause_ticks;
              chose = 1'b1;
            end else if (motion_mode == MODE_SWEEP && at_target) begin
              if (current_width == top_limit) begin
                top_hit = 1'b1;
              end else if (current_width == bottom_limit) begin
                bottom_hit = 1'b1;
              end
              target_width_next = (current_width < mid) ? sat_width({2'b00, bottom_limit})
                                                        : sat_width({2'b00, top_limit});
              pause_left_next   = sweep_pause_ticks;
              chose = 1'b1;
            end
            do_step = !chose || (pause_left_next == '0);
          end
        end
      end
      CMD_PWR_ON: begin
        powered_next = 1'b1;
      end
      CMD_PWR_OFF: begin
        powered_next = 1'b0;
      end
      CMD_JUMP: begin
        powered_next       = 1'b1;
        motion_mode_next   = MODE_FIXED;
        target_width_next  = req;
        current_width_next = req;
        pause_left_next    = '0;
      end
      CMD_MOVE: begin
        powered_next      = 1'b1;
        motion_mode_next  = MODE_FIXED;
        target_width_next = req;
        pause_left_next   = '0;
      end
      CMD_RANDOM: begin
        powered_next      = 1'b1;
        motion_mode_next  = MODE_RANDOM;
        target_width_next = current_width;
        pause_left_next   = '0;
      end
      CMD_SWEEP: begin
        powered_next = 1'b1;
        if (motion_mode != MODE_SWEEP) begin
          target_width_next = current_width;
          motion_mode_next  = MODE_SWEEP;
          pause_left_next   = '0;
        end
      end
      default: begin
      end
    endcase

    // Slew-limited step toward the (possibly new) target.
    if (target_width_next > current_width) begin
      diff = target_width_next - current_width;
    end else begin
      diff = current_width - target_width_next;
    end
    move = (diff < step_delta) ? diff : step_delta;
    if (do_step) begin
      if (target_width_next > current_width) begin
        current_width_next = current_width + move;
      end else begin
        current_width_next = current_width - move;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_stream.valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = need_mod ? ST_DIV : ST_WB;
      end
      ST_DIV: begin
        if (mod_done) begin
          state_next = ST_WB;
        end
      end
      ST_WB: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      top_limit          <= TOP_RST;
      bottom_limit       <= BOTTOM_RST;
      step_delta         <= DELTA_RST;
      random_pause_ticks <= '0;
      sweep_pause_ticks  <= '0;
      current_width      <= MIDDLE_RST;
      target_width       <= MIDDLE_RST;
      motion_mode        <= MODE_FIXED;
      powered            <= 1'b0;
      pause_left         <= '0;
      out_valid          <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_port.valid) begin
        case (cfg_port.index)
          REG_TOP:    top_limit          <= cfg_port.data[WIDTH_W-1:0];
          REG_BOTTOM: bottom_limit       <= cfg_port.data[WIDTH_W-1:0];
          REG_DELTA:  step_delta         <= cfg_port.data[WIDTH_W-1:0];
          REG_RPAUSE: random_pause_ticks <= cfg_port.data;
          REG_SPAUSE: sweep_pause_ticks  <= cfg_port.data;
          REG_MIDDLE: begin
          end
          default: begin
          end
        endcase
      end

      // Loading a new result wins over draining the old one in the same cycle.
      if (state == ST_WB && out_free) begin
        current_width <= current_width_next;
        target_width  <= target_width_next;
        motion_mode   <= motion_mode_next;
        powered       <= powered_next;
        pause_left    <= pause_left_next;
        out_valid     <= 1'b1;
      end else if (out_valid && result_stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: item latch and result data
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_stream.valid) begin
      cmd <= item_stream.command;
      req <= sat_width({1'b0, item_stream.requested_width});
      rnd <= item_stream.random_value;
    end
    if (state == ST_WB && out_free) begin
      out_pulse  <= current_width_next;
      out_power  <= powered_next;
      out_top    <= top_hit;
      out_bottom <= bottom_hit;
    end
  end

endmodule

[rtl/smpc_mod_unit.sv]
// Bit-serial remainder unit: one dividend bit per cycle, restoring compare and subtract.
module smpc_mod_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [smpc_pkg::RAND_W-1:0]    dividend,
  input  logic [smpc_pkg::SPAN_W-1:0]    divisor,
  output logic                           done,
  output logic [smpc_pkg::SPAN_W-1:0]    remainder
);
  import smpc_pkg::*;

  localparam int STEPS = RAND_W;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [RAND_W-1:0] dvd;
  logic [SPAN_W-1:0] dvs;
  logic [SPAN_W-1:0] rem;
  logic [SPAN_W:0]   shifted;
  logic [SPAN_W-1:0] rem_next;

  always_comb begin
    shifted = {rem, dvd[RAND_W-1]};
    if (shifted >= {1'b0, dvs}) begin
      rem_next = SPAN_W'(shifted - {1'b0, dvs});
    end else begin
      rem_next = shifted[SPAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // one-cycle pulse after the last step
      done <= busy && !start && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvd  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[RAND_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign remainder = rem;

endmodule
